// ===== sv/raster_to_block_reorder_assert.svh =====
// Assertion macros shared by the reorder block.
`ifndef RASTER_TO_BLOCK_REORDER_ASSERT_SVH
`define RASTER_TO_BLOCK_REORDER_ASSERT_SVH

// Same-cycle implication.
`define RTB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reorder check failed");

// Next-cycle implication.
`define RTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reorder check failed");

`endif

// ===== sv/rtb_pkg.sv =====
package rtb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_BLOCK  = 8;
  localparam int PIXEL_BITS = 8;

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int SROW_BITS  = $clog2(MAX_BLOCK);
  localparam int ADDR_BITS  = SROW_BITS + COL_BITS;
  localparam int STRIP_DEPTH = MAX_WIDTH * MAX_BLOCK;

  localparam int IW_BITS    = 11;
  localparam int IH_BITS    = 16;
  localparam int BS_BITS    = 4;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_WIDTH  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_HEIGHT = CFG_IDX_BITS'(3);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic size_err;
  } chk_status_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_BITS-1:0]  addr;
    logic [PIXEL_BITS-1:0] data;
  } strip_wr_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [BS_BITS-1:0] adjust_block(input logic [BS_BITS-1:0] b);
    logic [BS_BITS-1:0] r;
    if (b == '0) begin
      r = BS_BITS'(1);
    end else if (b > BS_BITS'(MAX_BLOCK)) begin
      r = BS_BITS'(MAX_BLOCK);
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

// ===== sv/rtb_strip_ram.sv =====
module rtb_strip_ram
  import rtb_pkg::*;
(
  input  logic                  clk,
  input  strip_wr_t             wr,
  input  logic                  rd_en,
  input  logic [ADDR_BITS-1:0]  rd_addr,
  output logic [PIXEL_BITS-1:0] rd_data
);

  logic [PIXEL_BITS-1:0] mem [STRIP_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/rtb_size_check.sv =====
module rtb_size_check
  import rtb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [IW_BITS-1:0] image_width,
  input  logic [IH_BITS-1:0] image_height,
  input  logic [BS_BITS-1:0] bw,
  input  logic [BS_BITS-1:0] bh,
  output chk_status_t        status
);

  localparam int CNT_BITS = $clog2(IH_BITS);

  logic                  busy;
  logic                  size_err;
  logic [CNT_BITS-1:0]   cnt;
  logic [SROW_BITS-1:0]  rem_w;
  logic [SROW_BITS-1:0]  rem_h;
  logic [SROW_BITS-1:0]  rem_w_next;
  logic [SROW_BITS-1:0]  rem_h_next;
  logic [IH_BITS-1:0]    w_ext;
  logic [BS_BITS-1:0]    tw;
  logic [BS_BITS-1:0]    th;
  logic                  err_final;

  // Restoring remainder, one dividend bit per cycle, MSB first.
  always_comb begin
    w_ext = IH_BITS'(image_width);
    tw    = {rem_w, w_ext[cnt]};
    th    = {rem_h, image_height[cnt]};
    rem_w_next = (tw >= bw) ? SROW_BITS'(tw - bw) : SROW_BITS'(tw);
    rem_h_next = (th >= bh) ? SROW_BITS'(th - bh) : SROW_BITS'(th);
    err_final  = (image_width == '0) || (image_width > IW_BITS'(MAX_WIDTH)) ||
                 (image_height == '0) || (rem_w_next != '0) || (rem_h_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy     <= 1'b1;
      cnt      <= CNT_BITS'(IH_BITS - 1);
      rem_w    <= '0;
      rem_h    <= '0;
      size_err <= 1'b0;
    end else if (busy) begin
      rem_w <= rem_w_next;
      rem_h <= rem_h_next;
      cnt   <= cnt - CNT_BITS'(1);
      if (cnt == '0) begin
        busy     <= 1'b0;
        size_err <= err_final;
      end
    end
  end

  assign status.busy     = busy;
  assign status.size_err = size_err;

endmodule

// ===== sv/raster_to_block_reorder.sv =====
// Bursts: a pixel that completes a block moves the state machine to ST_EMIT, where each of the
//   bw*bh block pixels is read from the single-read-port strip memory, one read at a time.
// Throughput: one input pixel per cycle between bursts, unless the size check is busy, a read is
//   pending or a size error waits on the output; input is held off during each burst.
// Reset and each write to a size register clear the position counters and run a size
//   check (one bit per cycle) during which no pixel is accepted. Strip memory is not cleared.
module raster_to_block_reorder
  import rtb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] pixel_in
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // [7:0] pixel_out
  output logic                     m_axis_tlast,   // block_end
  output logic [1:0]               m_axis_tuser,   // [0] image_end, [1] size_error
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  `include "raster_to_block_reorder_assert.svh"

  logic [IW_BITS-1:0]    image_width;
  logic [IH_BITS-1:0]    image_height;
  logic [BS_BITS-1:0]    block_width;
  logic [BS_BITS-1:0]    block_height;

  state_t                state;
  state_t                state_next;

  logic [COL_BITS-1:0]   col;
  logic [IH_BITS-1:0]    row;
  logic [SROW_BITS-1:0]  srow;
  logic [SROW_BITS-1:0]  bcol;
  logic [SROW_BITS-1:0]  r_cnt;
  logic [SROW_BITS-1:0]  c_cnt;
  logic [COL_BITS-1:0]   first_col;
  logic                  img_last;

  logic                  pend;
  logic                  pend_last;
  logic                  pend_img;
  logic                  out_valid;
  logic [PIXEL_BITS-1:0] out_data;
  logic                  out_last;
  logic                  out_img;
  logic                  out_err;

  logic                  cfg_write;
  logic                  cfg_hit;
  logic                  in_accept;
  logic                  out_accept;
  logic                  issue;
  logic                  burst_done;
  logic                  blk_done;
  logic                  col_end;
  logic                  row_end;
  logic [BS_BITS-1:0]    bw;
  logic [BS_BITS-1:0]    bh;
  logic [SROW_BITS-1:0]  bw_m1;
  logic [SROW_BITS-1:0]  bh_m1;

  chk_status_t           chk;
  strip_wr_t             wr;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [PIXEL_BITS-1:0] rd_data;

  assign bw    = adjust_block(block_width);
  assign bh    = adjust_block(block_height);
  assign bw_m1 = SROW_BITS'(bw - BS_BITS'(1));
  assign bh_m1 = SROW_BITS'(bh - BS_BITS'(1));

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign cfg_hit    = cfg_write && ((cfg_index == CFG_IMAGE_WIDTH) ||
                      (cfg_index == CFG_IMAGE_HEIGHT) || (cfg_index == CFG_BLOCK_WIDTH) ||
                      (cfg_index == CFG_BLOCK_HEIGHT));
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign out_accept = m_axis_tvalid && m_axis_tready;

  assign col_end    = ({1'b0, col} == (image_width - IW_BITS'(1)));
  assign row_end    = (row == (image_height - IH_BITS'(1)));
  assign blk_done   = (srow == bh_m1) && (bcol == bw_m1);
  assign burst_done = (r_cnt == bh_m1) && (c_cnt == bw_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IW_BITS'(640);
      image_height <= IH_BITS'(480);
      block_width  <= BS_BITS'(2);
      block_height <= BS_BITS'(2);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[IW_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[IH_BITS-1:0];
        CFG_BLOCK_WIDTH:  block_width  <= cfg_data[BS_BITS-1:0];
        CFG_BLOCK_HEIGHT: block_height <= cfg_data[BS_BITS-1:0];
        default: ;
      endcase
    end
  end

  rtb_size_check u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (cfg_hit),
    .image_width  (image_width),
    .image_height (image_height),
    .bw           (bw),
    .bh           (bh),
    .status       (chk)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && !chk.size_err && blk_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (issue && burst_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = !chk.busy && !pend && (!chk.size_err || !out_valid);
      end
      ST_EMIT: begin
        issue = !pend && (!out_valid || out_accept);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Raster position and position inside the current block row and strip.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col  <= '0;
      row  <= '0;
      srow <= '0;
      bcol <= '0;
    end else if (in_accept && !chk.size_err) begin
      if (col_end) begin
        col  <= '0;
        bcol <= '0;
        row  <= row_end ? '0 : row + IH_BITS'(1);
        srow <= (row_end || srow == bh_m1) ? '0 : srow + SROW_BITS'(1);
      end else begin
        col  <= col + COL_BITS'(1);
        bcol <= (bcol == bw_m1) ? '0 : bcol + SROW_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt <= '0;
      c_cnt <= '0;
    end else if (in_accept && !chk.size_err && blk_done) begin
      r_cnt <= '0;
      c_cnt <= '0;
    end else if (issue) begin
      if (c_cnt == bw_m1) begin
        c_cnt <= '0;
        r_cnt <= r_cnt + SROW_BITS'(1);
      end else begin
        c_cnt <= c_cnt + SROW_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && blk_done) begin
      first_col <= col - COL_BITS'(bw_m1);
      img_last  <= row_end && col_end;
    end
  end

  assign wr.en   = in_accept && !chk.size_err;
  assign wr.addr = {srow, col};
  assign wr.data = s_axis_tdata[PIXEL_BITS-1:0];
  assign rd_addr = {r_cnt, first_col + COL_BITS'(c_cnt)};

  rtb_strip_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // One read in flight; while pend is set, the read data from the strip memory is loaded into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_last <= burst_done;
      pend_img  <= burst_done && img_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend || (in_accept && chk.size_err)) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      out_data <= rd_data;
      out_last <= pend_last;
      out_img  <= pend_img;
      out_err  <= 1'b0;
    end else if (in_accept && chk.size_err) begin
      out_data <= '0;
      out_last <= 1'b0;
      out_img  <= 1'b0;
      out_err  <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = {out_err, out_img};

  `RTB_ASSERT_NOW(a_accept_idle, clk, rst, in_accept, (state == ST_IDLE) && !pend)
  `RTB_ASSERT_NEXT(a_pend_lands, clk, rst, pend, out_valid)
  `RTB_ASSERT_NOW(a_no_rw_mix, clk, rst, wr.en, !issue)
  `RTB_ASSERT_NOW(a_img_in_blk, clk, rst, out_valid && out_img, out_last && !out_err)
  `RTB_ASSERT_NOW(a_err_zero, clk, rst, out_valid && out_err, (out_data == '0) && !out_last)

endmodule
